// ===== hdl/rlsm_pkg.sv =====
// Package with the transfer types and fixed constants of the light sensor ring model.
package rlsm_pkg;

  // Input transfer: light offset from the robot and robot heading.
  typedef struct packed {
    logic signed [23:0] light_offset_x;
    logic signed [23:0] light_offset_y;
    logic [15:0]        heading;
  } in_item_t;

  // Output transfer: one reading per sensor, summary on the last one.
  typedef struct packed {
    logic [2:0]  sensor_index;
    logic [23:0] intensity;
    logic        is_last;
    logic [23:0] peak_intensity;
    logic [2:0]  peak_sensor;
    logic        thresh_hit;
  } out_item_t;

  // Register map, selected by address bit 2.
  localparam logic REG_RING_RADIUS = 1'b0;
  localparam logic REG_THRESHOLD   = 1'b1;

  localparam logic [22:0] RADIUS_RESET    = 23'd6554;
  localparam logic [23:0] THRESHOLD_RESET = 24'd819200;
  localparam logic [23:0] INTENSITY_MAX   = 24'hFFFFFF;

  // Sine polynomial coefficients, Q16.
  localparam logic [16:0] TRIG_C1      = 17'd102944;
  localparam logic [15:0] TRIG_C2      = 16'd42048;
  localparam logic [12:0] TRIG_C3      = 13'd4640;
  localparam logic [16:0] TRIG_ONE     = 17'd65536;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  // Distance, reciprocal and square root widths.
  localparam int DIST_W = 51;
  localparam int QUO_W  = 57;
  localparam int SQIN_W = 58;
  localparam int ROOT_W = 29;

endpackage

// ===== hdl/rlsm_trig.sv =====
// Four-stage pipelined sine and cosine of a binary angle, Q16 result.
module rlsm_trig #(
  parameter int TAG_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [15:0]        angle_i,
  input  logic [TAG_W-1:0]   tag_i,
  output logic               valid_o,
  output logic signed [17:0] sin_o,
  output logic signed [17:0] cos_o,
  output logic [TAG_W-1:0]   tag_o
);
  import rlsm_pkg::*;

  logic [3:0]             vld_q;
  logic [3:0][TAG_W-1:0]  tag_q;

  // Lane 0 computes sine, lane 1 cosine (sine a quarter turn ahead).
  logic [1:0][15:0] lane_ang;
  logic [1:0][16:0] a_x_d, a_x_q, b_x_q, c_x_q;
  logic [1:0][16:0] a_x2_d, a_x2_q, b_x2_q;
  logic [1:0]       a_neg_q, b_neg_q, c_neg_q, d_neg_unused;
  logic [1:0][15:0] b_t_d, b_t_q;
  logic [1:0][16:0] c_t_d, c_t_q;
  logic [1:0][17:0] d_s_d, d_s_q;

  assign lane_ang[0] = angle_i;
  assign lane_ang[1] = angle_i + QUARTER_TURN;
  assign d_neg_unused = '0;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [14:0] f;
    logic [33:0] pa, pc, pd;
    logic [29:0] pb;
    logic [17:0] s;
    logic [16:0] sc;

    // Stage A: fold into the first quadrant and square.
    always_comb begin
      if (lane_ang[l][14]) begin
        f = 15'(15'd16384 - {1'b0, lane_ang[l][13:0]});
      end else begin
        f = {1'b0, lane_ang[l][13:0]};
      end
      a_x_d[l] = {f, 2'b00};
      pa = 34'(a_x_d[l]) * 34'(a_x_d[l]);
      a_x2_d[l] = pa[32:16];
    end

    // Stage B: innermost polynomial term.
    always_comb begin
      pb = 30'(TRIG_C3) * 30'(a_x2_q[l]);
      b_t_d[l] = 16'(TRIG_C2 - {2'b00, pb[29:16]});
    end

    // Stage C: middle polynomial term.
    always_comb begin
      pc = 34'(b_t_q[l]) * 34'(b_x2_q[l]);
      c_t_d[l] = 17'(TRIG_C1 - pc[32:16]);
    end

    // Stage D: final product, clamp to one and apply the sign.
    always_comb begin
      pd = 34'(c_x_q[l]) * 34'(c_t_q[l]);
      s  = pd[33:16];
      sc = (s > {1'b0, TRIG_ONE}) ? TRIG_ONE : s[16:0];
      d_s_d[l] = c_neg_q[l] ? 18'(-{1'b0, sc}) : {1'b0, sc};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_x_q[l]   <= a_x_d[l];
        a_x2_q[l]  <= a_x2_d[l];
        a_neg_q[l] <= lane_ang[l][15];
        b_x_q[l]   <= a_x_q[l];
        b_x2_q[l]  <= a_x2_q[l];
        b_t_q[l]   <= b_t_d[l];
        b_neg_q[l] <= a_neg_q[l];
        c_x_q[l]   <= b_x_q[l];
        c_t_q[l]   <= c_t_d[l];
        c_neg_q[l] <= b_neg_q[l] ^ d_neg_unused[l];
        d_s_q[l]   <= d_s_d[l];
      end
    end
  end

  // Valid and side data travel alongside the arithmetic.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q <= {tag_q[2:0], tag_i};
    end
  end

  assign valid_o = vld_q[3];
  assign tag_o   = tag_q[3];
  assign sin_o   = d_s_q[0];
  assign cos_o   = d_s_q[1];

endmodule

// ===== hdl/rlsm_div.sv =====
// Pipelined restoring divider of the constant 2^(QW-1) by a divisor, one quotient bit per stage.
module rlsm_div #(
  parameter int DW    = 51,
  parameter int QW    = 57,
  parameter int TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DW-1:0]    den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [QW-1:0]    quo_o,
  output logic [TAG_W-1:0] tag_o
);

  logic [QW-1:0]            vld_q;
  logic [QW-1:0][DW-1:0]    rem_q, den_q;
  logic [QW-1:0][QW-1:0]    quo_q;
  logic [QW-1:0][TAG_W-1:0] tag_q;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    // Only the top bit of the dividend is set.
    localparam logic NUM_BIT = (k == 0);
    logic [DW-1:0]    rem_in, den_in, rem_nx;
    logic [QW-1:0]    quo_in;
    logic [TAG_W-1:0] tag_in;
    logic             vld_in, ge;
    logic [DW:0]      trial;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign den_in = den_i;
      assign tag_in = tag_i;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
      assign tag_in = tag_q[k-1];
      assign vld_in = vld_q[k-1];
    end

    // Shift in the next dividend bit and subtract where it fits.
    always_comb begin
      trial  = {rem_in, NUM_BIT};
      ge     = (trial >= {1'b0, den_in});
      rem_nx = ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_nx;
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[QW-2:0], ge};
        tag_q[k] <= tag_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

// ===== hdl/rlsm_sqrt.sv =====
// Pipelined integer square root, two radicand bits and one root bit per stage.
module rlsm_sqrt #(
  parameter int NW    = 58,
  parameter int TAG_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NW-1:0]     rad_i,
  input  logic [TAG_W-1:0]  tag_i,
  output logic              valid_o,
  output logic [NW/2-1:0]   root_o,
  output logic [TAG_W-1:0]  tag_o
);
  localparam int RTW = NW / 2;
  localparam int RW  = RTW + 2;

  logic [RTW-1:0]            vld_q;
  logic [RTW-1:0][RW-1:0]    rem_q;
  logic [RTW-1:0][RTW-1:0]   root_q;
  logic [RTW-1:0][NW-1:0]    rad_q;
  logic [RTW-1:0][TAG_W-1:0] tag_q;

  for (genvar k = 0; k < RTW; k++) begin : g_stage
    logic [RW-1:0]    rem_in, rem_nx;
    logic [RTW-1:0]   root_in;
    logic [NW-1:0]    rad_in;
    logic [TAG_W-1:0] tag_in;
    logic             vld_in, ge;
    logic [RW+1:0]    acc, trial;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign tag_in  = tag_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign tag_in  = tag_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // Bring down the next bit pair and test the trial root 4r+1.
    always_comb begin
      acc    = {rem_in, rad_in[NW-1-2*k -: 2]};
      trial  = (RW+2)'({root_in, 2'b01});
      ge     = (acc >= trial);
      rem_nx = ge ? RW'(acc - trial) : RW'(acc);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_nx;
        root_q[k] <= {root_in[RTW-2:0], ge};
        rad_q[k]  <= rad_in;
        tag_q[k]  <= tag_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end
  end

  assign valid_o = vld_q[RTW-1];
  assign root_o  = root_q[RTW-1];
  assign tag_o   = tag_q[RTW-1];

endmodule

// ===== hdl/ring_light_sensor_model_unit.sv =====
// Top level of the light sensor ring model: sequencer, geometry stages, output and registers.
//
// Each accepted input transfer yields SENSOR_COUNT output transfers, one per sensor in
// order 0 upward; the last also carries the peak intensity, the first sensor that holds
// it and the threshold flag. The sequencer issues one sensor per cycle into a single
// pipeline while the output is not stalled, taking the next input as it issues the last
// sensor of the current one, so there is no gap between items. Each sensor then passes the
// sine and cosine pipeline, the radius scaling, offset, squaring and summing registers, the
// reciprocal of the squared distance (one quotient bit per stage), its square root and the
// output register. The whole pipeline holds while a finished transfer is stalled.
// Registers: ring_radius at address 0, intensity_threshold at address 4; write them
// only while the block is idle.
module ring_light_sensor_model_unit #(
  parameter int SENSOR_COUNT = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rlsm_pkg::in_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rlsm_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import rlsm_pkg::*;

  localparam int IDX_W  = $clog2(SENSOR_COUNT);
  localparam int TRIG_T = IDX_W + 48;
  localparam int ARITH_T = IDX_W + 1;

  // Configuration registers.
  logic [22:0] radius_q;
  logic [23:0] thresh_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
      thresh_q <= THRESHOLD_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_RING_RADIUS: radius_q <= pwdata[22:0];
        REG_THRESHOLD:   thresh_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RING_RADIUS: prdata = {9'd0, radius_q};
      REG_THRESHOLD:   prdata = {8'd0, thresh_q};
      default:         prdata = '0;
    endcase
  end

  // Global pipeline advance: the output register is free or being taken.
  logic adv;
  logic out_valid_q;
  assign adv = !out_valid_q || !out_stall_i;

  // Sensor angle offsets, worked out at elaboration.
  logic [SENSOR_COUNT-1:0][15:0] ang_off;
  for (genvar gi = 0; gi < SENSOR_COUNT; gi++) begin : g_off
    assign ang_off[gi] = 16'((gi * 65536) / SENSOR_COUNT);
  end

  // Sequencer: hold the item and issue one sensor per cycle while the pipeline advances.
  logic             busy_q;
  logic [IDX_W-1:0] cnt_q;
  in_item_t         item_q;
  logic             last_job, accept;

  assign last_job   = (cnt_q == IDX_W'(SENSOR_COUNT - 1));
  assign in_stall_o = !adv || (busy_q && !last_job);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (accept) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (adv && busy_q) begin
      busy_q <= !last_job;
      cnt_q  <= last_job ? '0 : IDX_W'(cnt_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
  end

  // Sine and cosine of the sensor angle.
  logic               trig_vld;
  logic signed [17:0] trig_sin, trig_cos;
  logic [TRIG_T-1:0]  trig_tag;

  rlsm_trig #(
    .TAG_W(TRIG_T)
  ) u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (busy_q),
    .angle_i (16'(item_q.heading + ang_off[cnt_q])),
    .tag_i   ({cnt_q, item_q.light_offset_x, item_q.light_offset_y}),
    .valid_o (trig_vld),
    .sin_o   (trig_sin),
    .cos_o   (trig_cos),
    .tag_o   (trig_tag)
  );

  // Scale by the ring radius, rounding the magnitude half away from zero.
  logic [16:0]       mag_x, mag_y;
  logic [40:0]       prod_x, prod_y;
  logic [24:0]       sx_d, sy_d, e_sx_q, e_sy_q;
  logic [23:0]       e_ox_q, e_oy_q;
  logic [IDX_W-1:0]  e_idx_q;
  logic              e_vld_q;

  always_comb begin
    mag_x  = trig_cos[17] ? 17'(-trig_cos) : trig_cos[16:0];
    mag_y  = trig_sin[17] ? 17'(-trig_sin) : trig_sin[16:0];
    prod_x = 41'(radius_q) * 41'(mag_x) + 41'd32768;
    prod_y = 41'(radius_q) * 41'(mag_y) + 41'd32768;
    sx_d   = trig_cos[17] ? 25'(-{1'b0, prod_x[39:16]}) : {1'b0, prod_x[39:16]};
    sy_d   = trig_sin[17] ? 25'(-{1'b0, prod_y[39:16]}) : {1'b0, prod_y[39:16]};
  end

  // Offset from sensor to light, as magnitudes.
  logic [25:0]      dx, dy;
  logic [24:0]      f_ax_q, f_ay_q;
  logic [IDX_W-1:0] f_idx_q, g_idx_q, h_idx_q;
  logic             f_vld_q, g_vld_q, h_vld_q;

  always_comb begin
    dx = {{2{e_ox_q[23]}}, e_ox_q} - {e_sx_q[24], e_sx_q};
    dy = {{2{e_oy_q[23]}}, e_oy_q} - {e_sy_q[24], e_sy_q};
  end

  // Squares and squared distance.
  logic [49:0]       g_sqx_q, g_sqy_q;
  logic [DIST_W-1:0] h_d_q;
  logic              h_zero_q;
  logic [DIST_W-1:0] dist_sum;

  assign dist_sum = DIST_W'(g_sqx_q) + DIST_W'(g_sqy_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_sx_q   <= sx_d;
      e_sy_q   <= sy_d;
      e_ox_q   <= trig_tag[47:24];
      e_oy_q   <= trig_tag[23:0];
      e_idx_q  <= trig_tag[TRIG_T-1:48];
      f_ax_q   <= dx[25] ? 25'(-dx) : dx[24:0];
      f_ay_q   <= dy[25] ? 25'(-dy) : dy[24:0];
      f_idx_q  <= e_idx_q;
      g_sqx_q  <= 50'(f_ax_q) * 50'(f_ax_q);
      g_sqy_q  <= 50'(f_ay_q) * 50'(f_ay_q);
      g_idx_q  <= f_idx_q;
      h_d_q    <= dist_sum;
      h_zero_q <= (dist_sum == '0);
      h_idx_q  <= g_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
    end else if (adv) begin
      e_vld_q <= trig_vld;
      f_vld_q <= e_vld_q;
      g_vld_q <= f_vld_q;
      h_vld_q <= g_vld_q;
    end
  end

  // Reciprocal of the squared distance, then its square root.
  logic               div_vld, sq_vld;
  logic [QUO_W-1:0]   div_quo;
  logic [ARITH_T-1:0] div_tag, sq_tag;
  logic [ROOT_W-1:0]  root;

  rlsm_div #(
    .DW    (DIST_W),
    .QW    (QUO_W),
    .TAG_W (ARITH_T)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (h_vld_q),
    .den_i   (h_d_q),
    .tag_i   ({h_zero_q, h_idx_q}),
    .valid_o (div_vld),
    .quo_o   (div_quo),
    .tag_o   (div_tag)
  );

  rlsm_sqrt #(
    .NW    (SQIN_W),
    .TAG_W (ARITH_T)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (div_vld),
    .rad_i   (SQIN_W'(div_quo)),
    .tag_i   (div_tag),
    .valid_o (sq_vld),
    .root_o  (root),
    .tag_o   (sq_tag)
  );

  // Saturate, track the peak over the item and build the output transfer.
  logic [IDX_W-1:0] fin_idx, base_id, new_id, peak_id_q;
  logic [23:0]      inten, base_peak, new_peak, peak_q;
  logic             fin_last;
  out_item_t        out_d, out_q;

  always_comb begin
    fin_idx  = sq_tag[IDX_W-1:0];
    fin_last = (fin_idx == IDX_W'(SENSOR_COUNT - 1));
    if (sq_tag[IDX_W] || (root[ROOT_W-1:24] != '0)) begin
      inten = INTENSITY_MAX;
    end else begin
      inten = root[23:0];
    end
    base_peak = (fin_idx == '0) ? '0 : peak_q;
    base_id   = (fin_idx == '0) ? '0 : peak_id_q;
    if (inten > base_peak) begin
      new_peak = inten;
      new_id   = fin_idx;
    end else begin
      new_peak = base_peak;
      new_id   = base_id;
    end
    out_d.sensor_index   = 3'(fin_idx);
    out_d.intensity      = inten;
    out_d.is_last        = fin_last;
    out_d.peak_intensity = fin_last ? new_peak : '0;
    out_d.peak_sensor    = fin_last ? 3'(new_id) : '0;
    out_d.thresh_hit     = fin_last && (new_peak >= thresh_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
      if (sq_vld) begin
        peak_q    <= new_peak;
        peak_id_q <= new_id;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= sq_vld;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== verif/tb_ring_light_sensor_model_unit.sv =====
// Self-checking testbench for the light sensor ring model: random traffic, stalls and predicted readings.
module tb_ring_light_sensor_model_unit;
  import rlsm_pkg::*;

  localparam int NSENS = 8;
  localparam int PIPE_LAT = 100;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_item_t in_item_i;
  logic out_valid_o;
  logic out_stall_i;
  out_item_t out_item_o;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  ring_light_sensor_model_unit #(.SENSOR_COUNT(NSENS)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predictor copies of the two registers.
  logic [22:0] radius_q;
  logic [23:0] thresh_q;

  in_item_t  pending_lights[$];
  out_item_t expected_readings[$];
  int errors = 0;
  int readings_seen = 0;
  int items_sent = 0;
  bit feed_hold = 0;

  // Clock generation.
  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  // Polynomial sine of a binary angle, Q16.
  function automatic longint sine_q16(input logic [15:0] a);
    logic [1:0] q;
    longint f, x, x2, t, s;
    q = a[15:14];
    f = a[13:0];
    if (q[0]) f = 16384 - f;
    x = f * 4;
    x2 = (x * x) >>> 16;
    t = 42048 - ((4640 * x2) >>> 16);
    t = 102944 - ((t * x2) >>> 16);
    s = (x * t) >>> 16;
    if (s > 65536) s = 65536;
    return q[1] ? -s : s;
  endfunction

  // Radius times trig value, rounded half away from zero.
  function automatic longint ring_offset(input longint trig);
    longint mag, p;
    mag = trig < 0 ? -trig : trig;
    p = (longint'(radius_q) * mag + 32768) >>> 16;
    return trig < 0 ? -p : p;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Saturating inverse distance in Q12.12.
  function automatic logic [23:0] inverse_distance(input longint dx, input longint dy);
    logic [63:0] ax, ay, d, r;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    d = ax * ax + ay * ay;
    if (d == 0) return INTENSITY_MAX;
    r = int_sqrt((64'd1 << 56) / d);
    return (r > 64'hFFFFFF) ? INTENSITY_MAX : r[23:0];
  endfunction

  // Expected eight readings for one light position.
  task automatic predict_readings(input in_item_t it);
    logic [23:0] peak, inten;
    logic [2:0] peak_id;
    logic [15:0] ang;
    longint sx, sy;
    out_item_t o;
    peak = 0;
    peak_id = 0;
    for (int i = 0; i < NSENS; i++) begin
      ang = it.heading + 16'(i * (65536 / NSENS));
      sx = ring_offset(sine_q16(ang + QUARTER_TURN));
      sy = ring_offset(sine_q16(ang));
      inten = inverse_distance(longint'(it.light_offset_x) - sx,
                               longint'(it.light_offset_y) - sy);
      if (inten > peak) begin
        peak = inten;
        peak_id = 3'(i);
      end
      o = '0;
      o.sensor_index = 3'(i);
      o.intensity = inten;
      if (i == NSENS - 1) begin
        o.is_last = 1'b1;
        o.peak_intensity = peak;
        o.peak_sensor = peak_id;
        o.thresh_hit = (peak >= thresh_q);
      end
      expected_readings.push_back(o);
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Input driver: takes lights from the pending queue, random gaps between transfers.
  int in_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i <= '0;
      in_gap = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_readings(in_item_i);
        items_sent++;
        void'(pending_lights.pop_front());
        in_gap = gap_len();
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (in_gap > 0) in_gap--;
        if (in_gap == 0 && !feed_hold && pending_lights.size() > 0) begin
          in_valid_i <= 1'b1;
          in_item_i <= pending_lights[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor and random receiver stall.
  int stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        readings_seen++;
        if (expected_readings.size() == 0) begin
          errors++;
          $display("%0t: unexpected reading %p", $time, out_item_o);
        end else if (out_item_o !== expected_readings[0]) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time,
                   expected_readings[0], out_item_o);
          void'(expected_readings.pop_front());
        end else begin
          void'(expected_readings.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_left = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
        out_stall_i <= (stall_left > 0);
      end
    end
  end

  task automatic reg_write(input logic reg_sel, input logic [31:0] v);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {reg_sel, 2'b00}; pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (reg_sel == REG_RING_RADIUS) radius_q = v[22:0];
    else thresh_q = v[23:0];
  endtask

  // Waits until every queued light has been sent and all readings have come.
  task automatic drain();
    while (pending_lights.size() > 0 || expected_readings.size() > 0) @(posedge clk_i);
    repeat (PIPE_LAT) @(posedge clk_i);
  endtask

  function automatic in_item_t light_at(input int x, input int y, input int h);
    in_item_t it;
    it.light_offset_x = 24'(x);
    it.light_offset_y = 24'(y);
    it.heading = 16'(h);
    return it;
  endfunction

  // Mostly near lights, where intensity varies most; sometimes any position.
  function automatic in_item_t random_light();
    in_item_t it;
    it.heading = 16'($urandom());
    if ($urandom_range(0, 3) == 0) begin
      it.light_offset_x = 24'($urandom());
      it.light_offset_y = 24'($urandom());
    end else begin
      it.light_offset_x = 24'($signed(24'($urandom_range(0, 262143))) - 131072);
      it.light_offset_y = 24'($signed(24'($urandom_range(0, 262143))) - 131072);
    end
    return it;
  endfunction

  // Stimulus phases.
  initial begin
    radius_q = RADIUS_RESET;
    thresh_q = THRESHOLD_RESET;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    rst_ni = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;

    // Directed: light on a sensor, at the robot, extremes of the fields.
    pending_lights.push_back(light_at(6554, 0, 0));
    pending_lights.push_back(light_at(0, 0, 0));
    pending_lights.push_back(light_at(0, 0, 16'hFFFF));
    pending_lights.push_back(light_at(-8388608, -8388608, 16384));
    pending_lights.push_back(light_at(8388607, 8388607, 32768));
    pending_lights.push_back(light_at(8388607, -8388608, 49152));
    pending_lights.push_back(light_at(0, 6554, 8192));
    pending_lights.push_back(light_at(-6554, 0, 0));
    pending_lights.push_back(light_at(1, -1, 12345));
    pending_lights.push_back(light_at(65536, 0, 0));
    drain();

    // Zero radius: every sensor sees the same intensity, peak at sensor 0.
    reg_write(REG_RING_RADIUS, 0);
    reg_write(REG_THRESHOLD, 0);
    pending_lights.push_back(light_at(0, 0, 0));
    pending_lights.push_back(light_at(65536, 65536, 4000));
    pending_lights.push_back(light_at(8388607, 8388607, 0));
    for (int i = 0; i < 20; i++) pending_lights.push_back(random_light());
    drain();

    // Largest radius and threshold.
    reg_write(REG_RING_RADIUS, 32'h7FFFFF);
    reg_write(REG_THRESHOLD, 32'hFFFFFF);
    pending_lights.push_back(light_at(8388607, 0, 0));
    pending_lights.push_back(light_at(0, 0, 0));
    for (int i = 0; i < 20; i++) pending_lights.push_back(random_light());
    drain();

    // Random settings, with the feed held once until readings drain.
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(REG_RING_RADIUS, $urandom_range(0, 200000));
      reg_write(REG_THRESHOLD, $urandom_range(0, 2000000));
      for (int i = 0; i < 30; i++) pending_lights.push_back(random_light());
      if (ph == 1) begin
        while (pending_lights.size() > 15) @(posedge clk_i);
        feed_hold = 1;
        while (expected_readings.size() > 0) @(posedge clk_i);
        feed_hold = 0;
      end
      drain();
    end

    $display("Covered %0d light positions and %0d sensor readings", items_sent, readings_seen);
    $display("across reset, zero, maximum and random radius/threshold settings.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
